@@ rtl/core/mcsg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared types and constants for the midpoint circle span generator.
// ----------------------------------------------------------------------------
package mcsg_pkg;

  // input beat operation codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // span sequencing within one step
  localparam int unsigned SPAN_MAX = 8;
  localparam int unsigned IDX_W    = $clog2(SPAN_MAX);

  // last span index for each kind of step
  localparam logic [IDX_W-1:0] IDX_LAST_NONE    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_LAST_FILL_LO = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST_FILL_HI = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LAST_OUTLINE = IDX_W'(SPAN_MAX - 1);

  // result tuser bit positions
  localparam int unsigned TUSER_NO_SPAN = 0;
  localparam int unsigned TUSER_DONE    = 1;
  localparam int unsigned TUSER_W       = 2;

  // control flags handed from the state unit to the span emitter
  typedef struct packed {
    logic no_span;
    logic filled;
    logic done;
  } mcsg_ctl_t;

endpackage

@@ rtl/core/mcsg_state.sv @@
// ----------------------------------------------------------------------------
// mcsg_state
// Circle state registers and one midpoint iteration per accepted step beat.
// ----------------------------------------------------------------------------
module mcsg_state #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned RADIUS_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic                          mode,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0]        radius,
  input  logic                          fill_mode,
  output logic                          job_load,
  output mcsg_pkg::mcsg_ctl_t           job_ctl,
  output logic signed [COORD_BITS-1:0]  job_cx,
  output logic signed [COORD_BITS-1:0]  job_cy,
  output logic [RADIUS_BITS:0]          job_xs,
  output logic [RADIUS_BITS:0]          job_ys
);

  localparam int unsigned XW  = RADIUS_BITS + 1;
  localparam int unsigned CHW = RADIUS_BITS + 3;
  localparam int unsigned EW  = RADIUS_BITS + 4;
  localparam int unsigned TW  = EW + 2;

  logic                          active_r, active_nxt;
  logic                          filled_r, filled_nxt;
  logic signed [COORD_BITS-1:0]  cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0]  cy_r, cy_nxt;
  logic [XW-1:0]                 xs_r, xs_nxt;
  logic [XW-1:0]                 ys_r, ys_nxt;
  logic signed [CHW-1:0]         xch_r, xch_nxt;
  logic signed [CHW-1:0]         ych_r, ych_nxt;
  logic signed [EW-1:0]          rerr_r, rerr_nxt;

  logic                          live;
  logic signed [EW-1:0]          rerr_y;
  logic signed [TW-1:0]          test;
  logic                          x_move;
  logic [XW-1:0]                 xs_it, ys_it;
  logic signed [CHW-1:0]         xch_it;
  logic signed [EW-1:0]          rerr_it;

  // one midpoint iteration from the current point
  // xs is compared as signed since a zero radius steps it to minus one
  always_comb begin
    live    = active_r && !($signed(xs_r) < $signed(ys_r));
    ys_it   = ys_r + XW'(1);
    rerr_y  = rerr_r + EW'(ych_r);
    test    = (TW'(rerr_y) <<< 1) + TW'(xch_r);
    x_move  = (test > TW'(0));
    xs_it   = x_move ? (xs_r - XW'(1)) : xs_r;
    rerr_it = x_move ? (rerr_y + EW'(xch_r)) : rerr_y;
    xch_it  = x_move ? (xch_r + CHW'(2)) : xch_r;
  end

  // next state and job hand-off
  always_comb begin
    active_nxt = active_r;
    filled_nxt = filled_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    xs_nxt     = xs_r;
    ys_nxt     = ys_r;
    xch_nxt    = xch_r;
    ych_nxt    = ych_r;
    rerr_nxt   = rerr_r;
    job_load   = 1'b0;
    job_ctl    = '0;
    if (acc) begin
      if (mode == mcsg_pkg::MODE_START) begin
        active_nxt = 1'b1;
        filled_nxt = fill_mode;
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        xs_nxt     = XW'(radius);
        ys_nxt     = '0;
        xch_nxt    = CHW'(1) - $signed({2'b00, radius, 1'b0});
        ych_nxt    = '0;
        rerr_nxt   = '0;
      end else begin
        job_load        = 1'b1;
        job_ctl.no_span = !live;
        job_ctl.filled  = filled_r;
        if (live) begin
          xs_nxt       = xs_it;
          ys_nxt       = ys_it;
          xch_nxt      = xch_it;
          ych_nxt      = ych_r + CHW'(2);
          rerr_nxt     = rerr_it;
          job_ctl.done = ($signed(xs_it) < $signed(ys_it));
          active_nxt   = !($signed(xs_it) < $signed(ys_it));
        end else begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  assign job_cx = cx_r;
  assign job_cy = cy_r;
  assign job_xs = xs_r;
  assign job_ys = ys_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // circle payload
  always_ff @(posedge clk) begin
    filled_r <= filled_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    xs_r     <= xs_nxt;
    ys_r     <= ys_nxt;
    xch_r    <= xch_nxt;
    ych_r    <= ych_nxt;
    rerr_r   <= rerr_nxt;
  end

endmodule

@@ rtl/core/mcsg_emit.sv @@
// ----------------------------------------------------------------------------
// mcsg_emit
// Holds one step's point, walks its spans and drives the result register.
// ----------------------------------------------------------------------------
module mcsg_emit #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned RADIUS_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_load,
  input  mcsg_pkg::mcsg_ctl_t           job_ctl,
  input  logic signed [COORD_BITS-1:0]  job_cx,
  input  logic signed [COORD_BITS-1:0]  job_cy,
  input  logic [RADIUS_BITS:0]          job_xs,
  input  logic [RADIUS_BITS:0]          job_ys,
  output logic                          job_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [COORD_BITS:0]           res_y,
  output logic [COORD_BITS:0]           res_left,
  output logic [COORD_BITS:0]           res_right,
  output logic                          res_last,
  output logic                          res_no_span,
  output logic                          res_done
);

  localparam int unsigned XW = RADIUS_BITS + 1;
  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned SW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;

  logic                              job_vld_r;
  mcsg_pkg::mcsg_ctl_t               ctl_r;
  logic signed [COORD_BITS-1:0]      cx_r, cy_r;
  logic [XW-1:0]                     xs_r, ys_r;
  logic [mcsg_pkg::IDX_W-1:0]        idx_r;

  logic                              out_vld_r;
  logic [OW-1:0]                     y_r, left_r, right_r;
  logic [OW-1:0]                     y_nxt, left_nxt, right_nxt;
  logic                              last_r, nosp_r, done_r;

  logic signed [SW-1:0]              cxe, cye, xse, yse;
  logic signed [SW-1:0]              row_pys, row_mys, row_pxs, row_mxs;
  logic signed [SW-1:0]              col_mxs, col_pxs, col_mys, col_pys, col_pys1;
  logic [mcsg_pkg::IDX_W-1:0]        idx_last;
  logic                              is_last;
  logic                              adv;

  // candidate rows and columns around the center
  always_comb begin
    cxe      = SW'(cx_r);
    cye      = SW'(cy_r);
    xse      = $signed({{(SW-XW){1'b0}}, xs_r});
    yse      = $signed({{(SW-XW){1'b0}}, ys_r});
    row_pys  = cye + yse;
    row_mys  = cye - yse;
    row_pxs  = cye + xse;
    row_mxs  = cye - xse;
    col_mxs  = cxe - xse;
    col_pxs  = cxe + xse;
    col_mys  = cxe - yse;
    col_pys  = cxe + yse;
    col_pys1 = col_pys - SW'(1);
  end

  // span count for the held step
  always_comb begin
    if (ctl_r.no_span) begin
      idx_last = mcsg_pkg::IDX_LAST_NONE;
    end else if (ctl_r.filled) begin
      idx_last = (ys_r == '0) ? mcsg_pkg::IDX_LAST_FILL_LO : mcsg_pkg::IDX_LAST_FILL_HI;
    end else begin
      idx_last = mcsg_pkg::IDX_LAST_OUTLINE;
    end
    is_last = (idx_r == idx_last);
  end

  // span select for the current index
  always_comb begin
    y_nxt     = '0;
    left_nxt  = '0;
    right_nxt = '0;
    if (ctl_r.no_span) begin
      y_nxt = '0;
    end else if (ctl_r.filled) begin
      case (idx_r)
        3'd0: begin
          y_nxt = OW'(row_pys); left_nxt = OW'(col_mxs); right_nxt = OW'(col_pxs);
        end
        3'd1: begin
          y_nxt = OW'(row_mys); left_nxt = OW'(col_mxs); right_nxt = OW'(col_pxs);
        end
        3'd2: begin
          y_nxt = OW'(row_pxs); left_nxt = OW'(col_mys); right_nxt = OW'(col_pys1);
        end
        default: begin
          y_nxt = OW'(row_mxs); left_nxt = OW'(col_mys); right_nxt = OW'(col_pys1);
        end
      endcase
    end else begin
      case (idx_r)
        3'd0: begin
          y_nxt = OW'(row_pys); left_nxt = OW'(col_mxs);
        end
        3'd1: begin
          y_nxt = OW'(row_mys); left_nxt = OW'(col_mxs);
        end
        3'd2: begin
          y_nxt = OW'(row_mys); left_nxt = OW'(col_pxs);
        end
        3'd3: begin
          y_nxt = OW'(row_pys); left_nxt = OW'(col_pxs);
        end
        3'd4: begin
          y_nxt = OW'(row_pxs); left_nxt = OW'(col_mys);
        end
        3'd5: begin
          y_nxt = OW'(row_mxs); left_nxt = OW'(col_mys);
        end
        3'd6: begin
          y_nxt = OW'(row_mxs); left_nxt = OW'(col_pys);
        end
        default: begin
          y_nxt = OW'(row_pxs); left_nxt = OW'(col_pys);
        end
      endcase
      right_nxt = left_nxt;
    end
  end

  // handshake between the job slot and the result register
  assign adv       = job_vld_r && (!out_vld_r || res_ready);
  assign job_ready = !job_vld_r || (adv && is_last);

  // job slot and span index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (job_load) begin
      job_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (adv && is_last) begin
      job_vld_r <= 1'b0;
    end else if (adv) begin
      idx_r <= idx_r + mcsg_pkg::IDX_W'(1);
    end
  end

  // held point of the step
  always_ff @(posedge clk) begin
    if (job_load) begin
      ctl_r <= job_ctl;
      cx_r  <= job_cx;
      cy_r  <= job_cy;
      xs_r  <= job_xs;
      ys_r  <= job_ys;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (res_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      y_r     <= y_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      last_r  <= is_last;
      nosp_r  <= ctl_r.no_span;
      done_r  <= is_last && ctl_r.done;
    end
  end

  assign res_valid   = out_vld_r;
  assign res_y       = y_r;
  assign res_left    = left_r;
  assign res_right   = right_r;
  assign res_last    = last_r;
  assign res_no_span = nosp_r;
  assign res_done    = done_r;

  // an idle step has a single beat
  a_nospan_single: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r && ctl_r.no_span |-> idx_r == '0)
    else $error("no-span step walked past its only beat");

  // filled step on row zero gives two spans only
  a_fill_row0: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r && !ctl_r.no_span && ctl_r.filled && ys_r == '0
      |-> idx_r <= mcsg_pkg::IDX_LAST_FILL_LO)
    else $error("filled row-zero step exceeded two spans");

  // end of circle only flagged on the closing beat
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && done_r |-> last_r && !nosp_r)
    else $error("circle done flagged off the last beat");

  // a new job only lands in a free slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    job_load |-> job_ready)
    else $error("step job loaded over a busy slot");

endmodule

@@ rtl/core/midpoint_circle_span_generator.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_span_generator
// Loads a circle on a start beat, then emits the horizontal spans of one
// midpoint iteration for every step beat.
// ----------------------------------------------------------------------------
// result path: an accepted step beat is held in the job slot, and its first result
//   beat then moves into the result register once that is free; start beats
//   produce no result
// throughput: one result beat per cycle while out_tready takes them; a step
//   gives 1, 2, 4 or 8 beats, so filled circles give 2-4 and outlines 8 beats a step
// reset: synchronous active-low rst_n clears the active flag and both valids
// ----------------------------------------------------------------------------
module midpoint_circle_span_generator #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned RADIUS_BITS = 14
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // center_x, center_y, radius, fill_mode (from bit 0 up)
  input  logic [((2*COORD_BITS+RADIUS_BITS+1+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic                                         in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // span_y, span_left, span_right (from bit 0 up)
  output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0]        out_tdata,
  // no_span, circle_done (from bit 0 up)
  output logic [mcsg_pkg::TUSER_W-1:0]                 out_tuser,
  output logic                                         out_tlast
);

  localparam int unsigned OW      = COORD_BITS + 1;
  localparam int unsigned OUT_TW  = ((3*OW + 7) / 8) * 8;
  localparam int unsigned CX_LO   = 0;
  localparam int unsigned CY_LO   = CX_LO + COORD_BITS;
  localparam int unsigned RAD_LO  = CY_LO + COORD_BITS;
  localparam int unsigned FILL_AT = RAD_LO + RADIUS_BITS;

  logic                          acc;
  logic                          job_load;
  logic                          job_ready;
  mcsg_pkg::mcsg_ctl_t           job_ctl;
  logic signed [COORD_BITS-1:0]  job_cx, job_cy;
  logic [RADIUS_BITS:0]          job_xs, job_ys;
  logic [OW-1:0]                 res_y, res_left, res_right;
  logic                          res_no_span, res_done;

  // input beat acceptance
  assign in_tready = job_ready;
  assign acc       = in_tvalid && in_tready;

  mcsg_state #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .mode      (in_tuser),
    .center_x  ($signed(in_tdata[CX_LO +: COORD_BITS])),
    .center_y  ($signed(in_tdata[CY_LO +: COORD_BITS])),
    .radius    (in_tdata[RAD_LO +: RADIUS_BITS]),
    .fill_mode (in_tdata[FILL_AT]),
    .job_load  (job_load),
    .job_ctl   (job_ctl),
    .job_cx    (job_cx),
    .job_cy    (job_cy),
    .job_xs    (job_xs),
    .job_ys    (job_ys)
  );

  mcsg_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_load    (job_load),
    .job_ctl     (job_ctl),
    .job_cx      (job_cx),
    .job_cy      (job_cy),
    .job_xs      (job_xs),
    .job_ys      (job_ys),
    .job_ready   (job_ready),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_y       (res_y),
    .res_left    (res_left),
    .res_right   (res_right),
    .res_last    (out_tlast),
    .res_no_span (res_no_span),
    .res_done    (res_done)
  );

  // result beat packing
  assign out_tdata = OUT_TW'({res_right, res_left, res_y});
  always_comb begin
    out_tuser                          = '0;
    out_tuser[mcsg_pkg::TUSER_NO_SPAN] = res_no_span;
    out_tuser[mcsg_pkg::TUSER_DONE]    = res_done;
  end

endmodule

@@ verif/tb_midpoint_circle_span_generator.sv @@
// ----------------------------------------------------------------------------
// tb_midpoint_circle_span_generator
// Self-checking bench: drives start and step beats into the span generator,
// predicts every span beat of each midpoint iteration and compares them in
// order, under several phases of input idling and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midpoint_circle_span_generator;

  localparam int CB        = 16;
  localparam int RB        = 14;
  localparam int OB        = CB + 1;
  localparam int IN_W      = ((2*CB+RB+1+7)/8)*8;
  localparam int OUT_W     = ((3*OB+7)/8)*8;
  localparam int DRAIN_CYC = 8;
  localparam int WDOG_MAX  = 4000;
  localparam int RAND_ITEMS_PER_PHASE = 80;

  // one input beat, fields as they are packed in in_tuser and in_tdata
  typedef struct {
    logic          mode;
    logic [CB-1:0] center_x;
    logic [CB-1:0] center_y;
    logic [RB-1:0] radius;
    logic          fill_mode;
  } beat_t;

  // one expected span beat
  typedef struct {
    logic [OB-1:0] row;
    logic [OB-1:0] left;
    logic [OB-1:0] right;
    logic          no_span;
    logic          step_last;
    logic          done;
  } span_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [IN_W-1:0]              in_tdata = '0;
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [OUT_W-1:0]             out_tdata;
  logic [mcsg_pkg::TUSER_W-1:0] out_tuser;
  logic                         out_tlast;

  // predicted circle state
  bit     circ_active;
  bit     circ_filled;
  longint ctr_x, ctr_y;
  longint pt_x, pt_y;
  longint dx_term, dy_term, err_term;

  span_t  span_q[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_count = 0;
  int wdog_cnt  = 0;
  int n_starts  = 0;
  int n_steps   = 0;
  int n_spans   = 0;
  int n_circles = 0;

  midpoint_circle_span_generator #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic span_t mk_span(longint row, longint left, longint right);
    span_t s;
    s.row       = OB'(row);
    s.left      = OB'(left);
    s.right     = OB'(right);
    s.no_span   = 1'b0;
    s.step_last = 1'b0;
    s.done      = 1'b0;
    return s;
  endfunction

  // append one expected span beat
  function automatic void queue_span(span_t s);
    span_q.insert(span_q.size(), s);
  endfunction

  // circle state update and span prediction for one accepted beat
  task automatic predict_spans(beat_t b);
    span_t sp[8];
    int    n;
    n = 0;
    if (b.mode == mcsg_pkg::MODE_START) begin
      ctr_x       = longint'($signed(b.center_x));
      ctr_y       = longint'($signed(b.center_y));
      pt_x        = longint'(b.radius);
      pt_y        = 0;
      dx_term     = 1 - 2 * pt_x;
      dy_term     = 0;
      err_term    = 0;
      circ_filled = b.fill_mode;
      circ_active = 1'b1;
      n_starts++;
      return;
    end
    n_steps++;
    // step with no circle running
    if (!circ_active || pt_x < pt_y) begin
      circ_active  = 1'b0;
      sp[0]        = mk_span(0, 0, 0);
      sp[0].no_span   = 1'b1;
      sp[0].step_last = 1'b1;
      queue_span(sp[0]);
      return;
    end
    if (circ_filled) begin
      sp[n++] = mk_span(ctr_y + pt_y, ctr_x - pt_x, ctr_x + pt_x);
      sp[n++] = mk_span(ctr_y - pt_y, ctr_x - pt_x, ctr_x + pt_x);
      if (pt_y > 0) begin
        sp[n++] = mk_span(ctr_y + pt_x, ctr_x - pt_y, ctr_x + pt_y - 1);
        sp[n++] = mk_span(ctr_y - pt_x, ctr_x - pt_y, ctr_x + pt_y - 1);
      end
    end else begin
      sp[n++] = mk_span(ctr_y + pt_y, ctr_x - pt_x, ctr_x - pt_x);
      sp[n++] = mk_span(ctr_y - pt_y, ctr_x - pt_x, ctr_x - pt_x);
      sp[n++] = mk_span(ctr_y - pt_y, ctr_x + pt_x, ctr_x + pt_x);
      sp[n++] = mk_span(ctr_y + pt_y, ctr_x + pt_x, ctr_x + pt_x);
      sp[n++] = mk_span(ctr_y + pt_x, ctr_x - pt_y, ctr_x - pt_y);
      sp[n++] = mk_span(ctr_y - pt_x, ctr_x - pt_y, ctr_x - pt_y);
      sp[n++] = mk_span(ctr_y - pt_x, ctr_x + pt_y, ctr_x + pt_y);
      sp[n++] = mk_span(ctr_y + pt_x, ctr_x + pt_y, ctr_x + pt_y);
    end
    // midpoint error update
    pt_y     += 1;
    err_term += dy_term;
    dy_term  += 2;
    if (2 * err_term + dx_term > 0) begin
      pt_x     -= 1;
      err_term += dx_term;
      dx_term  += 2;
    end
    sp[n-1].step_last = 1'b1;
    if (pt_x < pt_y) begin
      circ_active    = 1'b0;
      sp[n-1].done   = 1'b1;
      n_circles++;
    end
    for (int i = 0; i < n; i++) queue_span(sp[i]);
  endtask

  // send one beat and predict it once accepted
  task automatic send_beat(beat_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.mode;
    in_tdata  <= IN_W'({b.fill_mode, b.radius, b.center_y, b.center_x});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_spans(b);
  endtask

  function automatic beat_t mk_start(int cx, int cy, int r, bit fill);
    beat_t b;
    b.mode      = mcsg_pkg::MODE_START;
    b.center_x  = CB'(cx);
    b.center_y  = CB'(cy);
    b.radius    = RB'(r);
    b.fill_mode = fill;
    return b;
  endfunction

  // step beat with random content in the unused fields
  function automatic beat_t mk_step();
    beat_t b;
    b.mode      = mcsg_pkg::MODE_STEP;
    b.center_x  = CB'($urandom);
    b.center_y  = CB'($urandom);
    b.radius    = RB'($urandom);
    b.fill_mode = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // start a circle, step it up to max_steps or its end, then extra steps
  task automatic run_circle(int cx, int cy, int r, bit fill, int max_steps, int extra);
    int cnt;
    cnt = 0;
    send_beat(mk_start(cx, cy, r, fill));
    while (circ_active && cnt < max_steps) begin
      send_beat(mk_step());
      cnt++;
    end
    repeat (extra) send_beat(mk_step());
  endtask

  // wait until every predicted span has arrived, then let the pipe settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    span_t exp_s;
    span_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.row       = out_tdata[OB-1:0];
      got.left      = out_tdata[2*OB-1:OB];
      got.right     = out_tdata[3*OB-1:2*OB];
      got.no_span   = out_tuser[mcsg_pkg::TUSER_NO_SPAN];
      got.done      = out_tuser[mcsg_pkg::TUSER_DONE];
      got.step_last = out_tlast;
      n_spans++;
      if (span_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: unexpected span beat y=%0d l=%0d r=%0d", $signed(got.row),
                   $signed(got.left), $signed(got.right));
      end else begin
        exp_s = span_q.pop_front();
        if (got.no_span !== exp_s.no_span || got.step_last !== exp_s.step_last ||
            got.done !== exp_s.done ||
            (!exp_s.no_span && (got.row !== exp_s.row || got.left !== exp_s.left ||
                                got.right !== exp_s.right))) begin
          err_count++;
          if (err_count <= 10) begin
            $display("ERROR: span exp y=%0d l=%0d r=%0d ns=%0b last=%0b done=%0b",
                     $signed(exp_s.row), $signed(exp_s.left), $signed(exp_s.right),
                     exp_s.no_span, exp_s.step_last, exp_s.done);
            $display("       span got y=%0d l=%0d r=%0d ns=%0b last=%0b done=%0b",
                     $signed(got.row), $signed(got.left), $signed(got.right),
                     got.no_span, got.step_last, got.done);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      wdog_cnt <= 0;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
      if (wdog_cnt >= WDOG_MAX) begin
        $display("watchdog expired with %0d spans outstanding", span_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // a step before any circle has been started
  task automatic test_idle_step();
    send_beat(mk_step());
    wait_drained();
  endtask

  // radius zero in both modes, row zero pair in filled mode
  task automatic test_zero_radius();
    run_circle(0, 0, 0, 1'b1, 100, 1);
    run_circle(-32768, 32767, 0, 1'b0, 100, 1);
    wait_drained();
  endtask

  // largest radius at the corners, restarting while a circle is running
  task automatic test_extreme_restart();
    run_circle(32767, 32767, 16383, 1'b1, 2, 0);
    run_circle(-32768, -32768, 16383, 1'b0, 2, 0);
    run_circle(32767, -32768, 16383, 1'b1, 1, 0);
    wait_drained();
  endtask

  // small circles stepped to their end
  task automatic test_small_circles();
    run_circle(100, -200, 1, 1'b1, 100, 1);
    run_circle(-32768, 32767, 3, 1'b0, 100, 0);
    wait_drained();
  endtask

  // mostly complete circles with random content, some noise and dropped circles
  task automatic test_random_traffic(int in_idle, int out_stall);
    int base;
    int pick;
    int r;
    int steps;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    base = n_starts + n_steps;
    while (n_starts + n_steps - base < RAND_ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 24);
        steps = (r <= 24) ? 1000 : $urandom_range(1, 6);
        run_circle($urandom, $urandom, r, 1'($urandom_range(0, 1)), steps,
                   ($urandom_range(0, 99) < 30) ? 1 : 0);
      end else if (pick < 85) begin
        send_beat(mk_step());
      end else begin
        steps = $urandom_range(0, 3);
        run_circle($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), steps, 0);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_step();
    test_zero_radius();
    test_extreme_restart();
    test_small_circles();
    test_random_traffic(0, 0);
    test_random_traffic(59, 0);
    test_random_traffic(0, 59);
    test_random_traffic(6, 6);

    if (span_q.size() != 0) err_count++;
    $display("run covered %0d start and %0d step beats, %0d span beats, %0d circles ended",
             n_starts, n_steps, n_spans, n_circles);
    $display("phases: no idling, sender idle, receiver stall, light mix; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
